### hdl/gbn_pkg.sv
// gbn_pkg: shared types and constants for the go-back-n sender window.
// Request, result and timer codes, controller states, parameter defaults.
// No dependencies.
package gbn_pkg;

	localparam int WINDOW_MAX_DEF   = 32;
	localparam int SEQ_BITS_DEF     = 16;
	localparam int PAYLOAD_BITS_DEF = 64;

	localparam int              CFG_W           = 6;
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 6'd8;

	typedef enum logic [1:0] {
		REQ_SEND    = 2'd0,
		REQ_ACK     = 2'd1,
		REQ_TIMEOUT = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		RES_PACKET  = 2'd0,
		RES_REFUSED = 2'd1,
		RES_TIMER   = 2'd2,
		RES_IGNORED = 2'd3
	} res_kind_t;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_START   = 2'd1,
		TMR_STOP    = 2'd2,
		TMR_RESTART = 2'd3
	} tmr_act_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_REPLAY = 1'b1
	} state_t;

endpackage

### hdl/gbn_ring_ram.sv
// gbn_ring_ram: payload ring storage, one write and one read port.
// Synchronous read. No dependencies.
module gbn_ring_ram #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/go_back_n_sender_window.sv
// go_back_n_sender_window: go-back-n sender window, uses gbn_pkg and gbn_ring_ram.
// Send, ack and refusal: one result, in the cycle after accept; busy stays low,
// so one such item per cycle.
// Timeout: timer result in the cycle after accept, then, if entries are held,
// one packet per cycle read from the ring RAM; busy until the last read returns.
// Reset: counters cleared, base and next sequence 1, window 8; ring not cleared.
// The receiver cannot stall: each result is a one-cycle result_valid strobe.
module go_back_n_sender_window #(
	parameter int WINDOW_MAX   = gbn_pkg::WINDOW_MAX_DEF,
	parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
	parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [gbn_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [PAYLOAD_BITS-1:0]   payload,
	input  logic [SEQ_BITS-1:0]       ack_number,
	input  logic                      ack_check_ok,
	output logic                      result_valid,
	output logic [1:0]                result_kind,
	output logic [SEQ_BITS-1:0]       packet_seq,
	output logic [PAYLOAD_BITS-1:0]   packet_data,
	output logic [1:0]                timer_action,
	output logic [SEQ_BITS-1:0]       timer_seq,
	output logic                      window_full,
	output logic                      last_of_run
);

	import gbn_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (32'(s) >= WINDOW_MAX) begin
			s = s - (CNT_W+1)'(WINDOW_MAX);
		end
		return IDX_W'(s);
	endfunction

	state_t                state_q, state_d;
	logic [CFG_W-1:0]      ws_q;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [IDX_W-1:0]      head_q, head_d;
	logic [SEQ_BITS-1:0]   base_q, base_d;
	logic [SEQ_BITS-1:0]   next_q, next_d;
	logic [CNT_W-1:0]      rp_i_q, rp_i_d;

	logic                  rp_valid_s1, rp_valid_d;
	logic                  rp_last_s1, rp_last_d;
	logic [SEQ_BITS-1:0]   rp_seq_s1, rp_seq_d;

	logic                  res_v_d;
	logic [1:0]            kind_d, tact_d;
	logic [SEQ_BITS-1:0]   seq_d, tseq_d;
	logic [PAYLOAD_BITS-1:0] data_d;
	logic                  full_d, last_d;

	logic [CNT_W-1:0]      eff;
	logic                  full_now;
	logic [SEQ_BITS-1:0]   ack_dist;
	logic [CNT_W-1:0]      num;
	logic                  wr_en, rd_en;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic [PAYLOAD_BITS-1:0] rd_data;

	gbn_ring_ram #(
		.DEPTH (WINDOW_MAX),
		.ADDR_W(IDX_W),
		.DATA_W(PAYLOAD_BITS)
	) u_ring (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(payload),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		if (ws_q == '0) begin
			eff = CNT_W'(1);
		end else if (32'(ws_q) > WINDOW_MAX) begin
			eff = CNT_W'(WINDOW_MAX);
		end else begin
			eff = CNT_W'(ws_q);
		end
	end

	assign full_now = (cnt_q >= eff);
	assign ack_dist = ack_number - base_q;
	assign num      = CNT_W'(32'(ack_dist) + 1);
	assign wr_addr  = ring_add(head_q, cnt_q);
	assign rd_addr  = ring_add(head_q, rp_i_q);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		head_d     = head_q;
		base_d     = base_q;
		next_d     = next_q;
		rp_i_d     = rp_i_q;
		rp_valid_d = 1'b0;
		rp_last_d  = 1'b0;
		rp_seq_d   = base_q + SEQ_BITS'(rp_i_q);
		res_v_d    = 1'b0;
		kind_d     = RES_PACKET;
		seq_d      = '0;
		data_d     = '0;
		tact_d     = TMR_NONE;
		tseq_d     = '0;
		full_d     = full_now;
		last_d     = 1'b1;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		busy       = 1'b1;

		// replay read data returns: emit the packet
		if (rp_valid_s1) begin
			res_v_d = 1'b1;
			seq_d   = rp_seq_s1;
			data_d  = rd_data;
			last_d  = rp_last_s1;
		end

		unique case (state_q)
			ST_IDLE: begin
				busy = rp_valid_s1;
				if (start && !rp_valid_s1) begin
					case (req_type)
						REQ_SEND: begin
							res_v_d = 1'b1;
							if (full_now) begin
								kind_d = RES_REFUSED;
								full_d = 1'b1;
							end else begin
								wr_en  = 1'b1;
								seq_d  = next_q;
								data_d = payload;
								if (cnt_q == '0) begin
									tact_d = TMR_START;
									tseq_d = next_q;
								end
								cnt_d  = cnt_q + CNT_W'(1);
								next_d = next_q + SEQ_BITS'(1);
								full_d = (cnt_q + CNT_W'(1)) >= eff;
							end
						end
						REQ_ACK: begin
							res_v_d = 1'b1;
							if (!ack_check_ok || cnt_q == '0 || 32'(ack_dist) >= 32'(cnt_q)) begin
								kind_d = RES_IGNORED;
							end else begin
								kind_d = RES_TIMER;
								base_d = ack_number + SEQ_BITS'(1);
								head_d = ring_add(head_q, num);
								cnt_d  = cnt_q - num;
								full_d = (cnt_q - num) >= eff;
								if (cnt_q == num) begin
									tact_d = TMR_STOP;
									tseq_d = base_q;
								end else begin
									tact_d = TMR_RESTART;
									tseq_d = ack_number + SEQ_BITS'(1);
								end
							end
						end
						REQ_TIMEOUT: begin
							res_v_d = 1'b1;
							kind_d  = RES_TIMER;
							tact_d  = TMR_RESTART;
							tseq_d  = base_q;
							last_d  = (cnt_q == '0);
							if (cnt_q != '0) begin
								state_d = ST_REPLAY;
								rp_i_d  = '0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_REPLAY: begin
				rd_en      = 1'b1;
				rp_valid_d = 1'b1;
				rp_last_d  = (rp_i_q + CNT_W'(1)) == cnt_q;
				rp_i_d     = rp_i_q + CNT_W'(1);
				if ((rp_i_q + CNT_W'(1)) == cnt_q) begin
					state_d = ST_IDLE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q         <= WINDOW_SIZE_RST;
			cnt_q        <= '0;
			head_q       <= '0;
			base_q       <= SEQ_BITS'(1);
			next_q       <= SEQ_BITS'(1);
			rp_i_q       <= '0;
			rp_valid_s1  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ws_q <= cfg_wr_data;
			end
			cnt_q        <= cnt_d;
			head_q       <= head_d;
			base_q       <= base_d;
			next_q       <= next_d;
			rp_i_q       <= rp_i_d;
			rp_valid_s1  <= rp_valid_d;
			result_valid <= res_v_d;
		end
	end

	always_ff @(posedge clk) begin
		rp_last_s1   <= rp_last_d;
		rp_seq_s1    <= rp_seq_d;
		result_kind  <= kind_d;
		packet_seq   <= seq_d;
		packet_data  <= data_d;
		timer_action <= tact_d;
		timer_seq    <= tseq_d;
		window_full  <= full_d;
		last_of_run  <= last_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= WINDOW_MAX)
		else $error("entry count beyond ring depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("ring write during replay");

	a_replay_out: assert property (@(posedge clk) disable iff (!arst_n)
		rp_valid_s1 |=> result_valid && result_kind == RES_PACKET)
		else $error("replay read without packet transfer");

	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == REQ_SEND || req_type == REQ_ACK)
		|=> result_valid && last_of_run)
		else $error("send or ack without single result");

	a_replay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REPLAY |=> busy)
		else $error("accepting while replay drains");

endmodule
